### rtl/core/tmma_pkg.sv
// Shared types and constants for the tile multiply-accumulate engine.
package tmma_pkg;

  // Field widths of the stream payloads
  localparam int KIND_W = 3;
  localparam int IDX_W  = 3;
  localparam int ELEM_W = 16;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 2 * ELEM_W;

  // Input tdata: row, col, element_value, accumulator_value, padded to bytes
  localparam int IN_FIELDS_W = 2 * IDX_W + ELEM_W + ACC_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata: out_row, out_col, out_value, padded to bytes
  localparam int OUT_FIELDS_W = 2 * IDX_W + ACC_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Saturation limits of the Q32.16 accumulator
  localparam logic [ACC_W-1:0] SAT_HI = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SAT_LO = {1'b1, {(ACC_W-1){1'b0}}};

  // Item kinds carried on tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A = 3'd0,
    KIND_LOAD_B = 3'd1,
    KIND_LOAD_C = 3'd2,
    KIND_MAC    = 3'd3,
    KIND_EMIT   = 3'd4
  } kind_e;

  // Control that travels with each MAC operand pair
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

### rtl/core/tmma_mac.sv
// Multiply and saturating accumulate datapath for one C element at a time.
module tmma_mac import tmma_pkg::*; #(
  parameter int AW = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic [AW-1:0]           addr_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  input  logic [ACC_W-1:0]        c_i,
  output logic                    wr_en_o,
  output logic [AW-1:0]           wr_addr_o,
  output logic [ACC_W-1:0]        wr_data_o,
  output logic                    busy_o
);

  mac_ctrl_t                ctrl_p_q;
  logic [AW-1:0]            addr_p_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         base_q;
  logic [ACC_W-1:0]         acc_q;
  logic [ACC_W-1:0]         acc_base;
  logic [ACC_W:0]           sum;
  logic [ACC_W-1:0]         acc_d;
  logic                     wr_q;
  logic [AW-1:0]            wr_addr_q;

  // Product stage: register the product and hold the starting C value
  always_ff @(posedge clk_i) begin
    prod_q   <= a_i * b_i;
    addr_p_q <= addr_i;
    if (ctrl_i.valid && ctrl_i.first) begin
      base_q <= c_i;
    end
  end

  // Add the product to the running sum and clamp to 48 bits
  always_comb begin
    acc_base = ctrl_p_q.first ? base_q : acc_q;
    sum = {acc_base[ACC_W-1], acc_base}
        + {{(ACC_W + 1 - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_d = sum[ACC_W] ? SAT_LO : SAT_HI;
    end else begin
      acc_d = sum[ACC_W-1:0];
    end
  end

  // Accumulate stage payload
  always_ff @(posedge clk_i) begin
    if (ctrl_p_q.valid) begin
      acc_q <= acc_d;
    end
    wr_addr_q <= addr_p_q;
  end

  // Track valid operands and raise a write after the final term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_p_q <= '0;
      wr_q     <= 1'b0;
    end else begin
      ctrl_p_q <= ctrl_i;
      wr_q     <= ctrl_p_q.valid && ctrl_p_q.last;
    end
  end

  assign wr_en_o   = wr_q;
  assign wr_addr_o = wr_addr_q;
  assign wr_data_o = acc_q;
  assign busy_o    = ctrl_p_q.valid || wr_q;

endmodule

### rtl/core/tile_matrix_multiply_accumulate.sv
// Top level of the tile engine: C += A*B on TILE x TILE tiles held in memories.
//
// Channel   Direction  Handshake              Contents
// s_axis    in         tvalid/tready          tuser kind; tdata row, col, element, accumulator
// m_axis    out        tvalid/tready, tlast   tdata out_row, out_col, out_value; tlast on last
//
// A multiply item runs one MAC per cycle through the single multiplier, with C read
// at the start and written back at the end of each element.
// An emit item streams TILE*TILE transfers, one per cycle while m_axis_tready_i is high.
// Reset clears control only; tile memories hold nothing valid until loaded.
// A stalled output holds one transfer in the output register and one in the memory read register.
module tile_matrix_multiply_accumulate import tmma_pkg::*; #(
  parameter int TILE = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [2:0] row, [5:3] col, [21:6] element_value, [69:22] accumulator_value, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [2:0] kind
  input  logic [KIND_W-1:0]      s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [2:0] out_row, [5:3] out_col, [53:6] out_value, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o
);

  localparam int IW    = $clog2(TILE);
  localparam int DEPTH = TILE * TILE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IW-1:0] IDX_MAX = IW'(TILE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Input field unpacking
  logic [IDX_W-1:0]  in_row;
  logic [IDX_W-1:0]  in_col;
  logic [ELEM_W-1:0] in_elem;
  logic [ACC_W-1:0]  in_acc;
  kind_e             in_kind;
  logic              in_inside;
  logic [AW-1:0]     ld_addr;
  logic              accept;

  assign in_row  = s_axis_tdata_i[IDX_W-1:0];
  assign in_col  = s_axis_tdata_i[2*IDX_W-1:IDX_W];
  assign in_elem = s_axis_tdata_i[2*IDX_W+ELEM_W-1:2*IDX_W];
  assign in_acc  = s_axis_tdata_i[IN_FIELDS_W-1:2*IDX_W+ELEM_W];
  assign in_kind = kind_e'(s_axis_tuser_i);
  assign in_inside = (int'(in_row) < TILE) && (int'(in_col) < TILE);
  assign ld_addr = AW'(int'(in_row) * TILE + int'(in_col));
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  // Sequencer counters
  logic [IW-1:0] i_q, j_q, m_q;
  logic [IW-1:0] er_q, ec_q;
  logic          mac_issue;
  logic          emit_issue;
  logic          move;
  logic          rd_pend_q;
  mac_ctrl_t     ctrl1_q;
  logic          mac_busy;

  logic [AW-1:0] a_raddr, b_raddr, mac_caddr, emit_addr;
  logic          m_first, m_last, j_last, i_last, ec_last, er_last;

  assign m_first = (m_q == '0);
  assign m_last  = (m_q == IDX_MAX);
  assign j_last  = (j_q == IDX_MAX);
  assign i_last  = (i_q == IDX_MAX);
  assign ec_last = (ec_q == IDX_MAX);
  assign er_last = (er_q == IDX_MAX);

  assign a_raddr   = AW'(int'(i_q) * TILE + int'(m_q));
  assign b_raddr   = AW'(int'(m_q) * TILE + int'(j_q));
  assign mac_caddr = AW'(int'(i_q) * TILE + int'(j_q));
  assign emit_addr = AW'(int'(er_q) * TILE + int'(ec_q));

  assign mac_issue  = (state_q == ST_MAC);
  assign move       = rd_pend_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign emit_issue = (state_q == ST_EMIT) && (!rd_pend_q || move);

  assign s_axis_tready_o = (state_q == ST_IDLE) && !ctrl1_q.valid && !mac_busy && !rd_pend_q;

  // Tile memories
  logic [ELEM_W-1:0] a_mem [DEPTH];
  logic [ELEM_W-1:0] b_mem [DEPTH];
  logic [ACC_W-1:0]  c_mem [DEPTH];

  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  logic [ACC_W-1:0]         c_rd_q;
  logic [AW-1:0]            caddr1_q;

  logic              mac_wr_en;
  logic [AW-1:0]     mac_wr_addr;
  logic [ACC_W-1:0]  mac_wr_data;
  logic              c_we, c_re;
  logic [AW-1:0]     c_waddr, c_raddr;
  logic [ACC_W-1:0]  c_wdata;

  // Load writes and MAC write-back never overlap: loads wait for the pipeline to drain
  assign c_we    = mac_wr_en || (accept && in_kind == KIND_LOAD_C && in_inside);
  assign c_waddr = mac_wr_en ? mac_wr_addr : ld_addr;
  assign c_wdata = mac_wr_en ? mac_wr_data : in_acc;
  assign c_re    = (mac_issue && m_first) || emit_issue;
  assign c_raddr = (state_q == ST_EMIT) ? emit_addr : mac_caddr;

  always_ff @(posedge clk_i) begin
    if (accept && in_kind == KIND_LOAD_A && in_inside) begin
      a_mem[ld_addr] <= in_elem;
    end
    if (mac_issue) begin
      a_rd_q <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_kind == KIND_LOAD_B && in_inside) begin
      b_mem[ld_addr] <= in_elem;
    end
    if (mac_issue) begin
      b_rd_q <= b_mem[b_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rd_q <= c_mem[c_raddr];
    end
  end

  // Multiply and accumulate datapath
  tmma_mac #(
    .AW (AW)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl1_q),
    .addr_i    (caddr1_q),
    .a_i       (a_rd_q),
    .b_i       (b_rd_q),
    .c_i       (c_rd_q),
    .wr_en_o   (mac_wr_en),
    .wr_addr_o (mac_wr_addr),
    .wr_data_o (mac_wr_data),
    .busy_o    (mac_busy)
  );

  // Sequencer: state, loop counters and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      m_q       <= '0;
      er_q      <= '0;
      ec_q      <= '0;
      ctrl1_q   <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      ctrl1_q.valid <= mac_issue;
      ctrl1_q.first <= m_first;
      ctrl1_q.last  <= m_last;

      if (emit_issue) begin
        rd_pend_q <= 1'b1;
      end else if (move) begin
        rd_pend_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept && in_kind == KIND_MAC) begin
            state_q <= ST_MAC;
            i_q     <= '0;
            j_q     <= '0;
            m_q     <= '0;
          end else if (accept && in_kind == KIND_EMIT) begin
            state_q <= ST_EMIT;
            er_q    <= '0;
            ec_q    <= '0;
          end
        end
        ST_MAC: begin
          // Advance inner index, then column, then row
          if (m_last) begin
            m_q <= '0;
            if (j_last) begin
              j_q <= '0;
              if (i_last) begin
                state_q <= ST_IDLE;
              end else begin
                i_q <= i_q + IW'(1);
              end
            end else begin
              j_q <= j_q + IW'(1);
            end
          end else begin
            m_q <= m_q + IW'(1);
          end
        end
        ST_EMIT: begin
          if (emit_issue) begin
            if (ec_last) begin
              ec_q <= '0;
              if (er_last) begin
                state_q <= ST_IDLE;
              end else begin
                er_q <= er_q + IW'(1);
              end
            end else begin
              ec_q <= ec_q + IW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Stage-one payload beside the memory read registers
  logic [IDX_W-1:0] rd_row_q, rd_col_q;
  logic             rd_last_q;

  always_ff @(posedge clk_i) begin
    caddr1_q <= mac_caddr;
    if (emit_issue) begin
      rd_row_q  <= IDX_W'(er_q);
      rd_col_q  <= IDX_W'(ec_q);
      rd_last_q <= er_last && ec_last;
    end
  end

  // Output register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic [ACC_W-1:0] out_value_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_row_q   <= rd_row_q;
      out_col_q   <= rd_col_q;
      out_value_q <= c_rd_q;
      out_last_q  <= rd_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            out_value_q, out_col_q, out_row_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

### verif/tb_tile_matrix_multiply_accumulate.sv
// Self-checking stream testbench for the tile multiply-accumulate engine.
module tb_tile_matrix_multiply_accumulate;
  timeunit 1ns;
  timeprecision 1ps;

  import tmma_pkg::*;

  localparam int TILE         = 8;
  localparam int N_ELEM       = TILE * TILE;
  localparam int MAC_CYCLES   = TILE * TILE * TILE + 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 13;
  localparam int SHOW_MAX     = 10;
  localparam int RANDOM_ITEMS = 20;

  // Kinds outside the enum that the engine must drop
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

  localparam logic [ELEM_W-1:0] ELEM_MIN  = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic [ELEM_W-1:0] ELEM_MAX  = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [IDX_W-1:0]  IDX_FIRST = '0;
  localparam logic [IDX_W-1:0]  IDX_FINAL = IDX_W'(TILE - 1);

  // One emitted C element
  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] value;
    logic             last;
  } c_elem_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // [2:0] row, [5:3] col, [21:6] element_value, [69:22] accumulator_value, rest zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // [2:0] kind
  logic [KIND_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // [2:0] out_row, [5:3] out_col, [53:6] out_value, rest zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Shadow tiles and the queue of C elements still owed by the engine
  logic signed [ELEM_W-1:0] a_mem [N_ELEM];
  logic signed [ELEM_W-1:0] b_mem [N_ELEM];
  logic signed [ACC_W-1:0]  c_mem [N_ELEM];
  c_elem_t                  tile_out_q [$];

  logic        steady;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned elems_checked;
  int unsigned mac_count;
  int unsigned emit_count;
  int unsigned clamp_count;

  tile_matrix_multiply_accumulate #(
    .TILE(TILE)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the output side at random, except in the steady stretch
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Clamp a running sum to the signed 48-bit range
  function automatic logic signed [ACC_W-1:0] saturate_q16(input longint sum);
    if (sum > longint'($signed(SAT_HI))) begin
      clamp_count++;
      return $signed(SAT_HI);
    end
    if (sum < longint'($signed(SAT_LO))) begin
      clamp_count++;
      return $signed(SAT_LO);
    end
    return sum[ACC_W-1:0];
  endfunction

  // C += A * B, clamping after every product in k order
  function automatic void accumulate_tiles();
    longint acc;
    longint prod;
    for (int i = 0; i < TILE; i++) begin
      for (int j = 0; j < TILE; j++) begin
        acc = c_mem[i*TILE + j];
        for (int k = 0; k < TILE; k++) begin
          prod = longint'(a_mem[i*TILE + k]) * longint'(b_mem[k*TILE + j]);
          acc  = saturate_q16(acc + prod);
        end
        c_mem[i*TILE + j] = acc[ACC_W-1:0];
      end
    end
  endfunction

  // Update the shadow tiles for one accepted item and queue any C elements it emits
  function automatic void apply_item(input logic [KIND_W-1:0] kind,
                                     input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                     input logic [ELEM_W-1:0] elem,
                                     input logic [ACC_W-1:0] accv);
    int      idx;
    c_elem_t e;
    idx = int'(row) * TILE + int'(col);
    case (kind)
      KIND_LOAD_A: begin
        if (row < TILE && col < TILE) a_mem[idx] = elem;
      end
      KIND_LOAD_B: begin
        if (row < TILE && col < TILE) b_mem[idx] = elem;
      end
      KIND_LOAD_C: begin
        if (row < TILE && col < TILE) c_mem[idx] = accv;
      end
      KIND_MAC: begin
        accumulate_tiles();
        mac_count++;
      end
      KIND_EMIT: begin
        for (int n = 0; n < N_ELEM; n++) begin
          e.row   = IDX_W'(n / TILE);
          e.col   = IDX_W'(n % TILE);
          e.value = c_mem[n];
          e.last  = (n == N_ELEM - 1);
          tile_out_q.push_back(e);
        end
        emit_count++;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return ELEM_MIN;
    if (pick == 1) return ELEM_MAX;
    return ELEM_W'($urandom);
  endfunction

  // Half the time near the clamp limits so that saturation gets exercised
  function automatic logic [ACC_W-1:0] rand_acc();
    logic [ACC_W-1:0] offset;
    offset = ACC_W'({$urandom_range(3), $urandom});
    case ($urandom_range(3))
      0:       return SAT_HI - offset;
      1:       return SAT_LO + offset;
      default: return ACC_W'({$urandom, $urandom});
    endcase
  endfunction

  // Present one item and hold it until the engine takes it
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                           input logic [ELEM_W-1:0] elem, input logic [ACC_W-1:0] accv);
    int gap;
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= IN_TDATA_W'({accv, elem, col, row});
    do @(posedge clk_i); while (!s_axis_tready);
    apply_item(kind, row, col, elem, accv);
    items_sent++;
  endtask

  task automatic send_random_fields(input logic [KIND_W-1:0] kind);
    send_item(kind, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom),
              ACC_W'({$urandom, $urandom}));
  endtask

  // Compare every output transfer with the oldest owed element
  always @(posedge clk_i) begin
    c_elem_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tile_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("[%0t] unexpected output transfer tdata=%h tlast=%b",
                   $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = tile_out_q.pop_front();
        elems_checked++;
        if (m_axis_tdata[IDX_W-1:0] !== want.row ||
            m_axis_tdata[2*IDX_W-1:IDX_W] !== want.col ||
            m_axis_tdata[2*IDX_W+ACC_W-1:2*IDX_W] !== want.value ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display({"[%0t] mismatch: expected row %0d col %0d value %h last %b, ",
                      "got row %0d col %0d value %h last %b"},
                     $time, want.row, want.col, want.value, want.last,
                     m_axis_tdata[IDX_W-1:0], m_axis_tdata[2*IDX_W-1:IDX_W],
                     m_axis_tdata[2*IDX_W+ACC_W-1:2*IDX_W], m_axis_tlast);
        end
      end
    end
  end

  // Write every entry of A, B and C so that no later read hits an unwritten one
  task automatic test_fill_tiles();
    for (int n = 0; n < N_ELEM; n++) begin
      send_item(KIND_LOAD_A, IDX_W'(n / TILE), IDX_W'(n % TILE), rand_elem(),
                ACC_W'({$urandom, $urandom}));
      send_item(KIND_LOAD_B, IDX_W'(n / TILE), IDX_W'(n % TILE), rand_elem(),
                ACC_W'({$urandom, $urandom}));
      send_item(KIND_LOAD_C, IDX_W'(n / TILE), IDX_W'(n % TILE), ELEM_W'($urandom),
                rand_acc());
    end
  endtask

  // Read back the loaded C tile untouched
  task automatic test_emit_loaded();
    send_random_fields(KIND_EMIT);
  endtask

  // Reserved kinds must leave every tile as it was
  task automatic test_reserved_kinds();
    for (int k = KIND_RSVD_LO; k <= KIND_RSVD_HI; k++)
      send_random_fields(KIND_W'(k));
    send_random_fields(KIND_EMIT);
  endtask

  // Extreme operands against accumulators already at the limits
  task automatic test_extremes();
    send_item(KIND_LOAD_A, IDX_FIRST, IDX_FIRST, ELEM_MIN, '0);
    send_item(KIND_LOAD_B, IDX_FIRST, IDX_FIRST, ELEM_MIN, '0);
    send_item(KIND_LOAD_A, IDX_FINAL, IDX_FIRST, ELEM_MIN, '1);
    send_item(KIND_LOAD_B, IDX_FIRST, IDX_FINAL, ELEM_MAX, '1);
    send_item(KIND_LOAD_A, IDX_FINAL, IDX_FINAL, ELEM_MAX, '0);
    send_item(KIND_LOAD_B, IDX_FINAL, IDX_FINAL, '0, '0);
    send_item(KIND_LOAD_C, IDX_FIRST, IDX_FIRST, '1, SAT_HI);
    send_item(KIND_LOAD_C, IDX_FINAL, IDX_FINAL, '1, SAT_LO);
    send_item(KIND_LOAD_C, IDX_FIRST, IDX_FINAL, '0, '0);
    send_random_fields(KIND_MAC);
    send_random_fields(KIND_EMIT);
    send_random_fields(KIND_MAC);
    send_random_fields(KIND_EMIT);
  endtask

  // Random mix of loads, multiplies and emits, with a stretch of unbroken traffic
  task automatic test_random_traffic();
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 4 && n < 16);
      pick   = $urandom_range(99);
      if (pick < 22)
        send_item(KIND_LOAD_A, IDX_W'($urandom), IDX_W'($urandom), rand_elem(),
                  ACC_W'({$urandom, $urandom}));
      else if (pick < 44)
        send_item(KIND_LOAD_B, IDX_W'($urandom), IDX_W'($urandom), rand_elem(),
                  ACC_W'({$urandom, $urandom}));
      else if (pick < 62)
        send_item(KIND_LOAD_C, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom),
                  rand_acc());
      else if (pick < 75)
        send_random_fields(KIND_MAC);
      else if (pick < 95)
        send_random_fields(KIND_EMIT);
      else
        send_random_fields(KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI)));
    end
    steady = 1'b0;
  endtask

  // Release the input, wait out the owed elements and any multiply still running
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tile_out_q.size() != 0) @(posedge clk_i);
    repeat (MAC_CYCLES + 16) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    steady        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_tiles();
    test_emit_loaded();
    test_reserved_kinds();
    test_extremes();
    test_random_traffic();
    drain();

    $display("covered %0d input transfers: %0d multiplies, %0d tile emits, %0d clamped sums",
             items_sent, mac_count, emit_count, clamp_count);
    $display("checked %0d output transfers, %0d mismatches", elems_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tmma_pkg.sv
rtl/core/tmma_mac.sv
rtl/core/tile_matrix_multiply_accumulate.sv
verif/tb_tile_matrix_multiply_accumulate.sv
